/* hw/rtl/knps_pkg.sv */
// Shared types and constants for the k-nearest point selector.
// No dependencies; imported by knps_dist and the top level.
`timescale 1ns / 1ps
`default_nettype none
package knps_pkg;

  localparam int unsigned MaxKeep = 32;
  localparam int unsigned IdxW    = $clog2(MaxKeep);
  localparam int unsigned CntW    = $clog2(MaxKeep + 1);
  localparam int unsigned CoordW  = 16;
  localparam int unsigned DistW   = 32;
  localparam int unsigned EntryW  = 3 * CoordW + DistW;
  localparam int unsigned KcfgW   = 6;
  localparam logic [KcfgW-1:0] KeepReset = KcfgW'(32);

  typedef struct packed {
    logic [DistW-1:0]  sq_dist;
    logic [CoordW-1:0] pz;
    logic [CoordW-1:0] py;
    logic [CoordW-1:0] px;
  } entry_t;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StShift,
    StEmitRd,
    StEmit
  } state_e;

endpackage
`default_nettype wire

/* hw/rtl/knps_ram.sv */
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module knps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* hw/rtl/knps_dist.sv */
// Squared-distance stage: one registered square per coordinate, then the sum.
// Depends on knps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module knps_dist (
  input  wire logic                         clk_i,
  input  wire logic                         load_i,
  input  wire logic [knps_pkg::CoordW-1:0] x_i,
  input  wire logic [knps_pkg::CoordW-1:0] y_i,
  input  wire logic [knps_pkg::CoordW-1:0] z_i,
  output logic      [knps_pkg::DistW-1:0]  dist_o
);
  import knps_pkg::*;

  logic [DistW-1:0] sx_q, sy_q, sz_q;
  logic signed [DistW-1:0] xs, ys, zs;

  // Sign-extend first so the products are formed at full width.
  assign xs = DistW'($signed(x_i));
  assign ys = DistW'($signed(y_i));
  assign zs = DistW'($signed(z_i));

  // Squares of signed 16-bit values fit in 31 bits; the sum fits in 32.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sx_q <= DistW'(xs * xs);
      sy_q <= DistW'(ys * ys);
      sz_q <= DistW'(zs * zs);
    end
  end

  assign dist_o = sx_q + sy_q + sz_q;
endmodule
`default_nettype wire

/* hw/rtl/k_nearest_point_select.sv */
// Top level of the k-nearest point selector: control sequencer, sorted store in RAM.
// Depends on knps_pkg, knps_dist and knps_ram.
//
//  channel  dir  fields (low bit first)                      handshake
//  s_axis   in   tdata: x,y,z (48b); tuser: end_of_set        tvalid/tready
//  m_axis   out  tdata: x,y,z,square_dist (80b); tlast        tvalid/tready
//  cfg      in   keep_count (6b)                              cfg_we_i
//
// After its accepting edge a point keeps the input stalled through a step that sums
// the squares and reads entry 0, up to the kept count of compare steps, a read and then
// a write for each entry moved one slot farther, and a step that writes the new point
// or drops it. A set end then drains the kept results, each word read and then captured,
// and the drain waits while the output stalls. Reset clears the kept count and the
// control state and sets k to 32; the store needs no clearing.
// A stalled output holds its word and the sequencer waits; input is taken only when idle.
`timescale 1ns / 1ps
`default_nettype none
module k_nearest_point_select (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [5:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // coord_x, coord_y, coord_z
  input  wire logic        s_axis_tuser,  // end_of_set
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,  // out_x, out_y, out_z, square_dist
  output logic             m_axis_tlast   // final_one
);
  import knps_pkg::*;

  state_e           state_q, state_d;
  logic [KcfgW-1:0] keep_q;
  logic [CntW-1:0]  total_q, total_d;
  logic [CntW-1:0]  pos_q, pos_d;     // scan pointer / emit pointer
  logic [CntW-1:0]  sh_q, sh_d;       // shift pointer (next slot to fill)
  logic             phase_q, phase_d; // 0: first cycle after accept
  logic             eos_q;
  entry_t           new_q;
  logic [CntW-1:0]  k_eff;

  logic             we;
  logic [IdxW-1:0]  waddr, raddr;
  entry_t           wdata, rdata;
  logic [DistW-1:0] dist_sum;

  logic             ovalid_q;
  entry_t           oent_q;
  logic             olast_q;

  // Saturate k to the store depth.
  assign k_eff = (keep_q > KcfgW'(MaxKeep)) ? CntW'(MaxKeep) : CntW'(keep_q);

  knps_dist u_dist (
    .clk_i (clk_i),
    .load_i(s_axis_tvalid && s_axis_tready),
    .x_i   (s_axis_tdata[15:0]),
    .y_i   (s_axis_tdata[31:16]),
    .z_i   (s_axis_tdata[47:32]),
    .dist_o(dist_sum)
  );

  knps_ram #(.Width(EntryW), .Depth(MaxKeep)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      keep_q   <= KeepReset;
      total_q  <= '0;
      pos_q    <= '0;
      sh_q     <= '0;
      phase_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      pos_q   <= pos_d;
      sh_q    <= sh_d;
      phase_q <= phase_d;
      if (cfg_we_i) begin
        keep_q <= cfg_wdata_i;
      end
      if (state_q == StEmit && (!ovalid_q || m_axis_tready)) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      new_q.px      <= s_axis_tdata[15:0];
      new_q.py      <= s_axis_tdata[31:16];
      new_q.pz      <= s_axis_tdata[47:32];
      new_q.sq_dist <= '0;
      eos_q         <= s_axis_tuser;
    end else if (state_q == StScan && !phase_q) begin
      new_q.sq_dist <= dist_sum;
    end
    if (state_q == StEmit && (!ovalid_q || m_axis_tready)) begin
      oent_q  <= rdata;
      olast_q <= (pos_q + CntW'(1) == total_q);
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {oent_q.sq_dist, oent_q.pz, oent_q.py, oent_q.px};
  assign m_axis_tlast  = olast_q;

  // Sequencer. During scan, raddr = pos_q and rdata returns that entry in the next cycle,
  // when pos_q has advanced past it; phase_q marks the cycle where the distance sum is first available.
  always_comb begin
    state_d = state_q;
    total_d = total_q;
    pos_d   = pos_q;
    sh_d    = sh_q;
    phase_d = phase_q;
    we      = 1'b0;
    waddr   = sh_q[IdxW-1:0];
    wdata   = rdata;
    raddr   = pos_q[IdxW-1:0];
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          state_d = StScan;
          pos_d   = '0;
          phase_d = 1'b0;
          if (total_q > k_eff) total_d = k_eff;
        end
      end
      StScan: begin
        // phase 0: raddr=0 issued, dist arrives. phase 1: rdata is entry pos_q-1.
        if (!phase_q) begin
          phase_d = 1'b1;
          pos_d   = CntW'(1);
          if (k_eff == '0) state_d = StIdle;
          else if (total_q == '0) begin
            pos_d = '0;
            sh_d  = '0;
            state_d = StShift;
          end
        end else if (rdata.sq_dist <= new_q.sq_dist) begin
          if (pos_q == total_q) begin
            pos_d   = total_q;
            sh_d    = total_q;
            state_d = StShift;
          end else begin
            pos_d = pos_q + CntW'(1);
          end
        end else begin
          pos_d   = pos_q - CntW'(1);
          sh_d    = (total_q < k_eff) ? total_q : k_eff - CntW'(1);
          state_d = StShift;
        end
        if (k_eff == '0) begin
          state_d = StIdle;
          total_d = '0;
        end
      end
      StShift: begin
        // pos_q = insertion slot. Move entry sh-1 to sh, reading it before the write.
        raddr = sh_q[IdxW-1:0] - IdxW'(1);
        if (pos_q >= k_eff) begin
          state_d = eos_q ? StEmitRd : StIdle;
          pos_d   = '0;
        end else if (sh_q == pos_q) begin
          we    = 1'b1;
          wdata = new_q;
          if (total_q < k_eff) total_d = total_q + CntW'(1);
          state_d = eos_q ? StEmitRd : StIdle;
          pos_d   = '0;
        end else if (!phase_q) begin
          we    = 1'b1;
          sh_d  = sh_q - CntW'(1);
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
        end
        if (state_d == StEmitRd) begin
          raddr = '0;
          if ((sh_q == pos_q && total_q == '0 && k_eff == '0) || total_d == '0) begin
            state_d = StIdle;
          end
        end
      end
      StEmitRd: begin
        raddr   = pos_q[IdxW-1:0];
        state_d = StEmit;
      end
      StEmit: begin
        raddr = pos_q[IdxW-1:0];
        if (!ovalid_q || m_axis_tready) begin
          if (pos_q + CntW'(1) == total_q) begin
            state_d = StIdle;
            total_d = '0;
          end else begin
            pos_d   = pos_q + CntW'(1);
            raddr   = pos_d[IdxW-1:0];
            state_d = StEmitRd;
          end
        end
      end
      default: state_d = StIdle;
    endcase
    // With k zero, a scan clears the count, so nothing is kept or emitted.
    if (state_q == StScan && k_eff == '0) total_d = '0;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) total_q <= CntW'(MaxKeep))
    else $error("kept count exceeds store depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !we)
    else $error("store written while idle");
endmodule
`default_nettype wire
